@@ hw/rtl/uule_pkg.sv @@
// ----------------------------------------------------------------------------
// uule_pkg
// Shared types, constants and the sextet character function of the line
// encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

    localparam int LINE_BYTES = 45;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int CNT_W      = $clog2(LINE_BYTES + 3);

    localparam logic [7:0] CHAR_OFFSET  = 8'h20;
    localparam logic [7:0] GRAVE_CHAR   = 8'h60;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_line;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic zag);
        logic [7:0] c;
        if (v == 6'd0) begin
            c = zag ? GRAVE_CHAR : CHAR_OFFSET;
        end else begin
            c = {2'b00, v} + CHAR_OFFSET;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/uule_line_ram.sv @@
// ----------------------------------------------------------------------------
// uule_line_ram
// Line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uule_line_ram
    import uule_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_wr    i_wr,
    input  t_ram_rd    i_rd,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [LINE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/uule_emit_seq.sv @@
// ----------------------------------------------------------------------------
// uule_emit_seq
// Line sequencer: buffers bytes, then fetches groups of three and shifts
// them out as sextet characters through one output register.
// ----------------------------------------------------------------------------
module uule_emit_seq
    import uule_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_zero_as_grave,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    output t_ram_wr    o_ram_wr,
    output t_ram_rd    o_ram_rd,
    input  logic [7:0] i_rd_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEN   = 5'b00010,
        S_FETCH = 5'b00100,
        S_CHR   = 5'b01000,
        S_NL    = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_base, n_base;
    logic [1:0]       r_fcnt, n_fcnt;
    logic [1:0]       r_ccnt, n_ccnt;
    logic [23:0]      r_grp, n_grp;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             w_accept;
    logic             w_slot;
    logic [CNT_W-1:0] w_fill_inc;
    logic [CNT_W-1:0] w_rem;
    logic [CNT_W-1:0] w_rd_idx;
    logic [CNT_W-1:0] w_base_inc;
    logic [7:0]       w_byte;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_fill_inc = r_fill + CNT_W'(1);
    assign w_rem      = r_n - r_base;
    assign w_rd_idx   = r_base + CNT_W'(r_fcnt);
    assign w_base_inc = r_base + CNT_W'(3);
    // bytes past the end of the line read as zero
    assign w_byte     = (CNT_W'(r_fcnt - 2'd1) < w_rem) ? i_rd_data : 8'h00;

    assign o_ram_wr.en   = w_accept;
    assign o_ram_wr.addr = r_fill[ADDR_W-1:0];
    assign o_ram_wr.data = i_in.data_byte;

    assign o_ram_rd.en   = (r_state == S_FETCH) && (r_fcnt != 2'd3)
                           && (w_rd_idx < CNT_W'(LINE_BYTES));
    assign o_ram_rd.addr = w_rd_idx[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_n         = r_n;
        n_base      = r_base;
        n_fcnt      = r_fcnt;
        n_ccnt      = r_ccnt;
        n_grp       = r_grp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.last_byte || (w_fill_inc == CNT_W'(LINE_BYTES))) begin
                        n_n     = w_fill_inc;
                        n_fill  = '0;
                        n_state = S_LEN;
                    end else begin
                        n_fill = w_fill_inc;
                    end
                end
            end
            S_LEN: begin
                if (w_slot) begin
                    n_out_valid       = 1'b1;
                    n_out.out_char    = 8'(CHAR_OFFSET + 8'(r_n));
                    n_out.end_of_line = 1'b0;
                    n_base            = '0;
                    n_fcnt            = '0;
                    n_state           = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_fcnt != 2'd0) begin
                    n_grp = {r_grp[15:0], w_byte};
                end
                n_fcnt = r_fcnt + 2'd1;
                if (r_fcnt == 2'd3) begin
                    n_ccnt  = '0;
                    n_state = S_CHR;
                end
            end
            S_CHR: begin
                if (w_slot) begin
                    n_out_valid       = 1'b1;
                    n_out.end_of_line = 1'b0;
                    if (CNT_W'(r_ccnt) <= w_rem) begin
                        n_out.out_char = sextet_char(r_grp[23:18], i_zero_as_grave);
                    end else begin
                        n_out.out_char = GRAVE_CHAR;
                    end
                    n_grp  = {r_grp[17:0], 6'd0};
                    n_ccnt = r_ccnt + 2'd1;
                    if (r_ccnt == 2'd3) begin
                        n_base = w_base_inc;
                        n_fcnt = '0;
                        if (w_base_inc >= r_n) begin
                            n_state = S_NL;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_NL: begin
                if (w_slot) begin
                    n_out_valid       = 1'b1;
                    n_out.out_char    = NEWLINE_CHAR;
                    n_out.end_of_line = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_base <= n_base;
        r_fcnt <= n_fcnt;
        r_ccnt <= n_ccnt;
        r_grp  <= n_grp;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hw/rtl/uu_line_encoder.sv @@
// ----------------------------------------------------------------------------
// uu_line_encoder
// Line-oriented uuencoder: gathers up to 45 bytes, then emits the length
// character, four characters per three bytes with grave padding, and a
// newline.
// ----------------------------------------------------------------------------
// A byte that does not close a line is written straight into the line buffer.
// Once a line closes, the input is held off while the sequencer emits it:
// each group of three bytes is fetched through the single registered read
// port of the line buffer (three reads, then the registered read data) and
// shifted out by the shared sextet shifter, one character per cycle while
// the output is not stalled. The next line's first byte is taken while the
// newline still waits in the output register. The zero_as_grave register
// may be written only while no line is in flight.
module uu_line_encoder
    import uule_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic       r_zero_as_grave;
    t_ram_wr    w_ram_wr;
    t_ram_rd    w_ram_rd;
    logic [7:0] w_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_as_grave <= 1'b0;
        end else if (i_cfg_we) begin
            r_zero_as_grave <= i_cfg_data;
        end
    end

    uule_line_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_ram_wr),
        .i_rd      (w_ram_rd),
        .o_rd_data (w_rd_data)
    );

    uule_emit_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_zero_as_grave (r_zero_as_grave),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in            (i_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out           (o_out),
        .o_ram_wr        (w_ram_wr),
        .o_ram_rd        (w_ram_rd),
        .i_rd_data       (w_rd_data)
    );

endmodule

@@ hw/rtl/uule_checker.sv @@
// ----------------------------------------------------------------------------
// uule_checker
// Port-level checks of the line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module uule_checker
    import uule_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_cfg_we,
    input logic      i_cfg_data,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // a flushing byte makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.last_byte |=> !o_in_ready)
        else $error("input still ready after last byte");

    // end of line only on newline
    a_eol_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.end_of_line |-> o_out.out_char == NEWLINE_CHAR)
        else $error("end of line on a non-newline beat");

    // while taking bytes only a newline can be pending
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out.end_of_line)
        else $error("data beat pending while input ready");

    // line characters stay in the printable range
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.end_of_line |->
            o_out.out_char >= CHAR_OFFSET && o_out.out_char <= GRAVE_CHAR)
        else $error("line character out of range");

endmodule

bind uu_line_encoder uule_checker u_chk (.*);
